// File: rtl/core/bnr_pkg.sv
package bnr_pkg;

    // Field widths of the transactions and registers.
    localparam int VALUE_W    = 32;
    localparam int FRAC_BITS  = 16;
    localparam int EXP_W      = 4;
    localparam int TGT_W      = 16;
    localparam int ITER_W     = 6;

    // Powers are held saturated to this signed width.
    localparam int POW_W      = 48;

    // The multiplier consumes the magnitude of x one digit per cycle, top digit first.
    localparam int DIGIT_W    = 16;
    localparam int NUM_DIGITS = (VALUE_W + DIGIT_W - 1) / DIGIT_W;
    localparam int DIG_TOT    = NUM_DIGITS * DIGIT_W;
    localparam int DCNT_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int PROD_W     = POW_W + DIG_TOT;
    localparam int QUO_W      = PROD_W - FRAC_BITS;
    localparam int NMAG_W     = QUO_W + 1;
    localparam int CMP_W      = POW_W + 1;

    localparam logic [POW_W-1:0] POS_LIM = {1'b0, {(POW_W-1){1'b1}}};
    localparam logic [POW_W-1:0] NEG_LIM = {1'b1, {(POW_W-1){1'b0}}};
    localparam logic [POW_W-1:0] FX_ONE  = POW_W'(1) << FRAC_BITS;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATIONS = 2'd2;

    localparam logic [EXP_W-1:0]  EXPONENT_RST   = 4'd2;
    localparam logic [TGT_W-1:0]  TARGET_RST     = 16'd2;
    localparam logic [ITER_W-1:0] ITERATIONS_RST = 6'd20;

    typedef struct packed {
        logic signed [VALUE_W-1:0] lower_end;
        logic signed [VALUE_W-1:0] upper_end;
    } bnr_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] root;
        logic                      no_root;
    } bnr_rsp_t;

    // Outcome of one evaluation of f: done pulses for one cycle, with the sign of f.
    typedef struct packed {
        logic done;
        logic neg;
        logic pos;
    } bnr_eval_t;

endpackage

// File: rtl/core/bnr_mul.sv
module bnr_mul
    import bnr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [POW_W-1:0] mul_a,
    input  logic [VALUE_W-1:0] mul_b,
    output logic             done,
    output logic [POW_W-1:0] product
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [DCNT_W-1:0]       cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    logic [POW_W-1:0]        am_reg, am_next;
    logic [DIG_TOT-1:0]      qd_reg, qd_next;
    logic                    neg_reg, neg_next;
    logic [PROD_W-1:0]       acc_reg, acc_next;
    logic [POW_W-1:0]        product_reg, product_next;

    logic [POW_W-1:0]         a_mag;
    logic [VALUE_W-1:0]       b_mag;
    logic [DIGIT_W-1:0]       digit;
    logic [POW_W+DIGIT_W-1:0] partial;
    logic [QUO_W-1:0]         quo;
    logic                     rem;
    logic [NMAG_W-1:0]        neg_mag;
    logic [POW_W-1:0]         mag_sat;
    logic [POW_W-1:0]         sat;

    assign a_mag   = mul_a[POW_W-1] ? (~mul_a) + POW_W'(1) : mul_a;
    assign b_mag   = mul_b[VALUE_W-1] ? (~mul_b) + VALUE_W'(1) : mul_b;
    assign digit   = qd_reg[DIG_TOT-1 -: DIGIT_W];
    assign partial = am_reg * digit;

    // Floor rounding: a negative product rounds its magnitude up.
    assign quo     = acc_reg[PROD_W-1:FRAC_BITS];
    assign rem     = |acc_reg[FRAC_BITS-1:0];
    assign neg_mag = {1'b0, quo} + NMAG_W'(rem);

    always_comb
    begin
        mag_sat = NEG_LIM;
        if (!neg_reg)
        begin
            sat = (quo > QUO_W'(POS_LIM)) ? POS_LIM : quo[POW_W-1:0];
        end
        else
        begin
            if (neg_mag <= NMAG_W'(NEG_LIM))
            begin
                mag_sat = neg_mag[POW_W-1:0];
            end
            sat = (~mag_sat) + POW_W'(1);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        am_next      = am_reg;
        qd_next      = qd_reg;
        neg_next     = neg_reg;
        acc_next     = acc_reg;
        product_next = product_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    am_next    = a_mag;
                    qd_next    = DIG_TOT'(b_mag);
                    neg_next   = mul_a[POW_W-1] ^ mul_b[VALUE_W-1];
                    acc_next   = '0;
                    cnt_next   = DCNT_W'(NUM_DIGITS - 1);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                acc_next = (acc_reg << DIGIT_W) + PROD_W'(partial);
                qd_next  = qd_reg << DIGIT_W;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - DCNT_W'(1);
                end
            end
            ST_FIN:
            begin
                product_next = sat;
                done_next    = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        am_reg      <= am_next;
        qd_reg      <= qd_next;
        neg_reg     <= neg_next;
        acc_reg     <= acc_next;
        product_reg <= product_next;
    end

    assign done    = done_reg;
    assign product = product_reg;

endmodule

// File: rtl/core/bnr_pow.sv
module bnr_pow
    import bnr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] x,
    input  logic [EXP_W-1:0]   exponent,
    input  logic [TGT_W-1:0]   target,
    output bnr_eval_t          eval
);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_LOOP = 2'd1;
    localparam logic [1:0] P_WAIT = 2'd2;
    localparam logic [1:0] P_CMP  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [EXP_W-1:0]   cnt_reg, cnt_next;
    bnr_eval_t          eval_reg, eval_next;
    logic [POW_W-1:0]   acc_reg, acc_next;
    logic [VALUE_W-1:0] x_reg, x_next;

    logic               mul_start;
    logic               mul_done;
    logic [POW_W-1:0]   mul_product;
    logic signed [CMP_W-1:0] acc_fx;
    logic signed [CMP_W-1:0] tgt_fx;

    assign mul_start = (state_reg == P_LOOP) && (cnt_reg != '0);

    bnr_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mul_a   (acc_reg),
        .mul_b   (x_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    // Only the sign of x^n - t is needed, so compare instead of subtracting.
    assign acc_fx = CMP_W'($signed(acc_reg));
    assign tgt_fx = CMP_W'($signed(target)) << FRAC_BITS;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        eval_next      = eval_reg;
        eval_next.done = 1'b0;
        acc_next       = acc_reg;
        x_next         = x_reg;
        case (state_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    acc_next   = FX_ONE;
                    cnt_next   = exponent;
                    x_next     = x;
                    state_next = P_LOOP;
                end
            end
            P_LOOP:
            begin
                state_next = (cnt_reg == '0) ? P_CMP : P_WAIT;
            end
            P_WAIT:
            begin
                if (mul_done)
                begin
                    acc_next   = mul_product;
                    cnt_next   = cnt_reg - EXP_W'(1);
                    state_next = P_LOOP;
                end
            end
            P_CMP:
            begin
                eval_next.done = 1'b1;
                eval_next.neg  = acc_fx < tgt_fx;
                eval_next.pos  = acc_fx > tgt_fx;
                state_next     = P_IDLE;
            end
            default:
            begin
                state_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            cnt_reg   <= '0;
            eval_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            eval_reg  <= eval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
    end

    assign eval = eval_reg;

endmodule

// File: rtl/core/bisection_nth_root_top.sv
// Bisection root finder for f(x) = x^n - t over a signed Q16.16 interval [a, b].
// A request transaction carries the two endpoints; the response carries the last
// midpoint (0 if N is 0) and a no_root flag, set when f(a) and f(b) are not of
// strictly opposite sign (root is then 0). The exponent n, the integer target t and
// the halving count N are set through the cfg port; the user must set them only
// while the block is idle, which the block itself does not enforce. N is limited
// to MAX_ITERATIONS. Each evaluation of f runs n fixed-point products through one
// shared multiplier that takes a 48-bit factor times one 16-bit digit of x per
// cycle, two digits per product. A request with a sign change evaluates f at a,
// at b and at N midpoints; one without a sign change evaluates f only at a and b.
// req_ready is high only while no request is in progress; a finished response
// sits in its own register, so the next request may start before it is taken.
module bisection_nth_root_top
    import bnr_pkg::*;
#(
    parameter int MAX_ITERATIONS = 63
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  bnr_req_t              req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output bnr_rsp_t              rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ICNT_W = $clog2(MAX_ITERATIONS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVA   = 3'd1;
    localparam logic [2:0] S_EVB   = 3'd2;
    localparam logic [2:0] S_ITER  = 3'd3;
    localparam logic [2:0] S_IWAIT = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [EXP_W-1:0]  exponent_reg;
    logic [TGT_W-1:0]  target_reg;
    logic [ITER_W-1:0] iterations_reg;

    logic [2:0]          state_reg, state_next;
    logic [ICNT_W-1:0]   iter_cnt_reg, iter_cnt_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic                sa_neg_reg, sa_neg_next;
    logic                sa_pos_reg, sa_pos_next;
    logic signed [VALUE_W-1:0] neg_reg, neg_next;
    logic signed [VALUE_W-1:0] pos_reg, pos_next;
    logic signed [VALUE_W-1:0] x_reg, x_next;
    bnr_rsp_t            result_reg, result_next;
    bnr_rsp_t            rsp_reg, rsp_next;

    logic                pow_start;
    logic [VALUE_W-1:0]  pow_x;
    bnr_eval_t           eval;
    logic [VALUE_W:0]    sum;
    logic [VALUE_W-1:0]  mid;
    logic [ICNT_W-1:0]   n_clamped;
    logic                opposite;
    logic                rsp_load;

    bnr_pow u_pow (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pow_start),
        .x        (pow_x),
        .exponent (exponent_reg),
        .target   (target_reg),
        .eval     (eval)
    );

    // Configuration registers; writes to an index past the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg   <= EXPONENT_RST;
            target_reg     <= TARGET_RST;
            iterations_reg <= ITERATIONS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_EXPONENT:   exponent_reg   <= cfg_data[EXP_W-1:0];
                CFG_TARGET:     target_reg     <= cfg_data[TGT_W-1:0];
                CFG_ITERATIONS: iterations_reg <= cfg_data[ITER_W-1:0];
                default:        ;
            endcase
        end
    end

    // Floor of (pos + neg) / 2 always fits the value width.
    assign sum = {pos_reg[VALUE_W-1], pos_reg} + {neg_reg[VALUE_W-1], neg_reg};
    assign mid = sum[VALUE_W:1];

    assign n_clamped = (int'(iterations_reg) > MAX_ITERATIONS) ?
                       ICNT_W'(MAX_ITERATIONS) : ICNT_W'(iterations_reg);

    assign opposite = (sa_neg_reg & eval.pos) | (sa_pos_reg & eval.neg);
    assign rsp_load = (state_reg == S_OUT) && (!rsp_valid_reg || rsp_ready);
    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        pow_start = 1'b0;
        pow_x     = mid;
        case (state_reg)
            S_IDLE:
            begin
                pow_start = req_valid;
                pow_x     = req.lower_end;
            end
            S_EVA:
            begin
                pow_start = eval.done;
                pow_x     = pos_reg;
            end
            S_ITER:
            begin
                pow_start = (iter_cnt_reg != '0);
            end
            default:
            begin
                pow_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        iter_cnt_next  = iter_cnt_reg;
        sa_neg_next    = sa_neg_reg;
        sa_pos_next    = sa_pos_reg;
        neg_next       = neg_reg;
        pos_next       = pos_reg;
        x_next         = x_reg;
        result_next    = result_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    // Hold a and b here until their signs decide which side each is.
                    neg_next   = req.lower_end;
                    pos_next   = req.upper_end;
                    state_next = S_EVA;
                end
            end
            S_EVA:
            begin
                if (eval.done)
                begin
                    sa_neg_next = eval.neg;
                    sa_pos_next = eval.pos;
                    state_next  = S_EVB;
                end
            end
            S_EVB:
            begin
                if (eval.done)
                begin
                    if (!opposite)
                    begin
                        result_next.root    = '0;
                        result_next.no_root = 1'b1;
                        state_next          = S_OUT;
                    end
                    else
                    begin
                        if (sa_pos_reg)
                        begin
                            neg_next = pos_reg;
                            pos_next = neg_reg;
                        end
                        iter_cnt_next = n_clamped;
                        x_next        = '0;
                        state_next    = S_ITER;
                    end
                end
            end
            S_ITER:
            begin
                if (iter_cnt_reg == '0)
                begin
                    result_next.root    = x_reg;
                    result_next.no_root = 1'b0;
                    state_next          = S_OUT;
                end
                else
                begin
                    x_next        = mid;
                    iter_cnt_next = iter_cnt_reg - ICNT_W'(1);
                    state_next    = S_IWAIT;
                end
            end
            S_IWAIT:
            begin
                if (eval.done)
                begin
                    // An exact zero of f leaves both points in place.
                    if (eval.neg)
                    begin
                        neg_next = x_reg;
                    end
                    else if (eval.pos)
                    begin
                        pos_next = x_reg;
                    end
                    state_next = S_ITER;
                end
            end
            S_OUT:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_next       = result_reg;
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_cnt_reg  <= iter_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_neg_reg <= sa_neg_next;
        sa_pos_reg <= sa_pos_next;
        neg_reg    <= neg_next;
        pos_reg    <= pos_next;
        x_reg      <= x_next;
        result_reg <= result_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: dv/bisection_nth_root_top_tb.sv
`timescale 1ns / 1ps

module bisection_nth_root_top_tb
    import bnr_pkg::*;
();

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int REPORT_MAX = 10;
    localparam int RANDOM_PHASES = 9;
    localparam int EXTREME_PHASE = 4;
    localparam int PHASE_ITEMS = 68;
    localparam int EXTREME_ITEMS = 12;
    localparam int LONG_HOLD_AT = 320;
    localparam int LONG_HOLD_CYCLES = 3000;
    localparam int TAIL_CYCLES = 200;

    // Only three registers exist; this index should be ignored by the block.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic { ROW_WRITE, ROW_ITEM } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        bnr_req_t              item;
        bit                    fixed;
        bnr_rsp_t              answer;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    bnr_req_t              req = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    bnr_rsp_t              rsp;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Register values as the block should hold them.
    logic [EXP_W-1:0]         cur_exponent = 4'd2;
    logic signed [TGT_W-1:0]  cur_target = 16'sd2;
    logic [ITER_W-1:0]        cur_halvings = 6'd20;

    bnr_rsp_t  pending_roots[$];
    stim_row_t plan[$];
    int        send_idle_pct = 29;
    int        recv_idle_pct = 72;
    int        mismatch_count = 0;
    int        results_seen = 0;
    int        cycle_count = 0;

    bisection_nth_root_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Q16.16 product with floor rounding, saturated to the 48-bit power range.
    function automatic logic signed [POW_W-1:0] fixed_mul(input logic signed [POW_W-1:0] p,
                                                          input logic signed [VALUE_W-1:0] x);
        logic signed [95:0] prod;
        logic signed [95:0] quot;
        prod = 96'(p) * 96'(x);
        quot = prod >>> FRAC_BITS;
        if (quot[95:POW_W-1] != {(97-POW_W){quot[95]}})
            return quot[95] ? {1'b1, {(POW_W-1){1'b0}}} : {1'b0, {(POW_W-1){1'b1}}};
        return quot[POW_W-1:0];
    endfunction

    // Sign of x^n - t: -1, 0 or +1.
    function automatic int f_polarity(input logic signed [VALUE_W-1:0] x);
        logic signed [POW_W-1:0] acc;
        logic signed [POW_W:0]   diff;
        acc = POW_W'(1) << FRAC_BITS;
        for (int k = 0; k < cur_exponent; k++)
            acc = fixed_mul(acc, x);
        diff = (POW_W+1)'(acc) - ((POW_W+1)'(cur_target) <<< FRAC_BITS);
        return (diff < 0) ? -1 : ((diff > 0) ? 1 : 0);
    endfunction

    function automatic bnr_rsp_t predict_root(input bnr_req_t r);
        bnr_rsp_t                   out;
        int                         sa;
        int                         sb;
        int                         sm;
        logic signed [VALUE_W-1:0]  neg_pt;
        logic signed [VALUE_W-1:0]  pos_pt;
        logic signed [VALUE_W:0]    total;
        out.root = '0;
        out.no_root = 1'b1;
        sa = f_polarity(r.lower_end);
        sb = f_polarity(r.upper_end);
        if (sa * sb >= 0)
            return out;
        out.no_root = 1'b0;
        neg_pt = (sa < 0) ? r.lower_end : r.upper_end;
        pos_pt = (sa < 0) ? r.upper_end : r.lower_end;
        // The 6-bit count can never exceed the block's iteration ceiling.
        for (int k = 0; k < cur_halvings; k++)
        begin
            total = (VALUE_W+1)'(pos_pt) + (VALUE_W+1)'(neg_pt);
            out.root = VALUE_W'(total >>> 1);
            sm = f_polarity(out.root);
            if (sm < 0)
                neg_pt = out.root;
            else if (sm > 0)
                pos_pt = out.root;
        end
        return out;
    endfunction

    function automatic logic signed [VALUE_W-1:0] random_point();
        logic signed [VALUE_W-1:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, VALUE_W - 1);
    endfunction

    // Most intervals are redrawn, for at most 40 tries, until they bracket a root; the rest are left as drawn.
    function automatic bnr_req_t pick_interval();
        bnr_req_t r;
        bit       bracket;
        bracket = ($urandom_range(0, 99) < 80);
        for (int k = 0; k < 40; k++)
        begin
            r.lower_end = random_point();
            r.upper_end = random_point();
            if (!bracket || f_polarity(r.lower_end) * f_polarity(r.upper_end) < 0)
                break;
        end
        return r;
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = '{kind: ROW_WRITE, index: idx, data: data, item: '0, fixed: 1'b0,
                answer: '0};
        plan.push_back(row);
    endfunction

    function automatic void add_item(input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b);
        stim_row_t row;
        row = '{kind: ROW_ITEM, index: '0, data: '0, item: {a, b}, fixed: 1'b0,
                answer: '0};
        plan.push_back(row);
    endfunction

    function automatic void add_known(input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b,
                                      input logic [VALUE_W-1:0] root, input logic no_root);
        stim_row_t row;
        row = '{kind: ROW_ITEM, index: '0, data: '0, item: {a, b}, fixed: 1'b1,
                answer: {root, no_root}};
        plan.push_back(row);
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_EXPONENT:   cur_exponent = data[EXP_W-1:0];
            CFG_TARGET:     cur_target = data[TGT_W-1:0];
            CFG_ITERATIONS: cur_halvings = data[ITER_W-1:0];
            default: ;
        endcase
    endtask

    // Valid stays high between back-to-back transactions; it drops only for a gap.
    task automatic send_request(input bnr_req_t item, input bit fixed, input bnr_rsp_t answer);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req <= item;
        do @(posedge clk); while (!req_ready);
        pending_roots.push_back(fixed ? answer : predict_root(item));
    endtask

    task automatic settle_block();
        req_valid <= 1'b0;
        while (pending_roots.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_result(input bnr_rsp_t got);
        bnr_rsp_t want;
        results_seen++;
        if (pending_roots.size() == 0)
        begin
            if (mismatch_count < REPORT_MAX)
                $display("unexpected response: root %h no_root %b", got.root, got.no_root);
            mismatch_count++;
        end
        else
        begin
            want = pending_roots.pop_front();
            if (got.root !== want.root || got.no_root !== want.no_root)
            begin
                if (mismatch_count < REPORT_MAX)
                    $display("response %0d: root expected %h got %h, no_root expected %b got %b",
                             results_seen, want.root, got.root, want.no_root, got.no_root);
                mismatch_count++;
            end
        end
    endtask

    // Response side, with one long hold-off so the block backs up into the request port.
    initial
    begin
        int hold_left;
        bit long_hold_done;
        hold_left = 0;
        long_hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                check_result(rsp);
            if (!long_hold_done && results_seen == LONG_HOLD_AT)
            begin
                hold_left = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin
        int                      items;
        logic [EXP_W-1:0]        exp_val;
        logic [TGT_W-1:0]        tgt_val;
        logic [ITER_W-1:0]       iter_val;

        // Reset settings: x^2 - 2.
        add_known(32'h0000_0000, 32'h0000_0000, 32'h0, 1'b1);
        add_known(32'h0002_0000, 32'h0002_0000, 32'h0, 1'b1);
        add_item(32'h0000_0000, 32'h0002_0000);
        add_item(32'hFFFE_0000, 32'h0000_0000);
        add_known(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1);
        add_item(32'h7FFF_FFFF, 32'h0000_0000);
        add_known(32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 1'b1);
        // x - 2: the first midpoint of [0, 4] is an exact zero and never moves.
        add_write(CFG_EXPONENT, 16'hFFF1);
        add_known(32'h0000_0000, 32'h0004_0000, 32'h0002_0000, 1'b0);
        add_known(32'h0004_0000, 32'h0000_0000, 32'h0002_0000, 1'b0);
        add_write(CFG_ITERATIONS, 16'h0000);
        add_known(32'h0000_0000, 32'h0004_0000, 32'h0, 1'b0);
        add_known(32'h0002_0000, 32'h0002_0000, 32'h0, 1'b1);
        add_write(CFG_ITERATIONS, 16'hFFFF);
        add_item(32'h8000_0000, 32'h7FFF_FFFF);
        add_write(CFG_TARGET, 16'h8000);
        add_known(32'h8000_0000, 32'h0000_0000, 32'h0, 1'b1);
        add_known(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1);
        add_write(CFG_TARGET, 16'h7FFF);
        add_item(32'h0000_0000, 32'h7FFF_FFFF);
        // x^0 is 1.0 everywhere, so there is never a sign change.
        add_write(CFG_EXPONENT, 16'h0000);
        add_known(32'h0000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1);
        add_write(CFG_EXPONENT, 16'h000F);
        add_write(CFG_TARGET, 16'h0003);
        add_write(CFG_ITERATIONS, 16'h000A);
        add_item(32'h0000_0000, 32'h0002_0000);
        add_item(32'h8000_0000, 32'h7FFF_FFFF);
        add_item(32'hFFFF_0000, 32'h7FFF_FFFF);
        // x^3 + 8: the first midpoint of [-4, 0] is the exact root -2.
        add_write(CFG_EXPONENT, 16'h0003);
        add_write(CFG_TARGET, 16'hFFF8);
        add_write(CFG_ITERATIONS, 16'h0014);
        add_known(32'hFFFC_0000, 32'h0000_0000, 32'hFFFE_0000, 1'b0);
        add_item(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_write(CFG_SPARE, 16'hFFFF);
        add_known(32'hFFFC_0000, 32'h0000_0000, 32'hFFFE_0000, 1'b0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                settle_block();
                write_register(plan[i].index, plan[i].data);
            end
            else
            begin
                if (cfg_valid)
                    cfg_valid <= 1'b0;
                send_request(plan[i].item, plan[i].fixed, plan[i].answer);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 3)
            begin
                send_idle_pct = 29;
                recv_idle_pct = 72;
            end
            else if (p < 6)
            begin
                send_idle_pct = 72;
                recv_idle_pct = 29;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // The slowest setting gets only a handful of transactions.
            if (p == EXTREME_PHASE)
            begin
                exp_val = 4'd15;
                iter_val = 6'd63;
                items = EXTREME_ITEMS;
            end
            else
            begin
                exp_val = 4'($urandom_range(1, 6));
                iter_val = 6'($urandom_range(1, 24));
                items = PHASE_ITEMS;
            end
            if ($urandom_range(0, 3) == 0)
                tgt_val = 16'($urandom);
            else
                tgt_val = 16'($urandom_range(0, 300)) - 16'd40;

            settle_block();
            write_register(CFG_EXPONENT, {12'($urandom), exp_val});
            write_register(CFG_TARGET, tgt_val);
            write_register(CFG_ITERATIONS, {10'($urandom), iter_val});
            cfg_valid <= 1'b0;
            for (int n = 0; n < items; n++)
                send_request(pick_interval(), 1'b0, '0);
        end

        settle_block();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
